### design/byte_ring_queue_with_peek_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the byte ring queue with peek unit.
// Every macro checks on the rising clock edge and is disabled while reset is
// asserted.
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_QUEUE_WITH_PEEK_UNIT_DEFINES_SVH
`define BYTE_RING_QUEUE_WITH_PEEK_UNIT_DEFINES_SVH

// A condition that must hold at every clock edge.
`define BRQ_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its trigger.
`define BRQ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define BRQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/brq_pkg.sv
// ----------------------------------------------------------------------------
// brq_pkg
// Shared constants, operation codes and transaction types of the byte ring
// queue with peek unit.
// ----------------------------------------------------------------------------
package brq_pkg;

    localparam int DEPTH  = 1024;
    localparam int BURST  = 8;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = 11;
    localparam int LEN_W  = 4;
    localparam int BYTE_W = 8;
    localparam int LANE_W = 3;
    localparam int DATA_W = 64;

    localparam logic [1:0] OP_PUT       = 2'd0;
    localparam logic [1:0] OP_GET       = 2'd1;
    localparam logic [1:0] OP_PEEK      = 2'd2;
    localparam logic [1:0] OP_PEEK_NEXT = 2'd3;

    typedef struct packed {
        logic [1:0]        operation;
        logic [LEN_W-1:0]  length;
        logic [DATA_W-1:0] put_bytes;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0] read_bytes;
        logic [LEN_W-1:0]  moved;
        logic [CNT_W-1:0]  fill_level;
        logic [CNT_W-1:0]  free_space;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic setup;
        logic run;
        logic commit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic run_done;
    } t_dp_sts;

endpackage

### design/brq_ram.sv
// ----------------------------------------------------------------------------
// brq_ram
// Generic single-port RAM with a registered read port.
// ----------------------------------------------------------------------------
module brq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/brq_dp.sv
// ----------------------------------------------------------------------------
// brq_dp
// Datapath: ring pointers, fill and peek counters, the byte store and the
// byte gather register that builds each result.
// ----------------------------------------------------------------------------
`include "byte_ring_queue_with_peek_unit_defines.svh"

module brq_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  brq_pkg::t_dp_cmd   i_cmd,
    output brq_pkg::t_dp_sts   o_sts,
    input  brq_pkg::t_in_item  i_in,
    output brq_pkg::t_out_item o_out
);
    import brq_pkg::*;

    // Architectural state.
    logic [PTR_W-1:0]  r_rp;
    logic [PTR_W-1:0]  r_wp;
    logic [PTR_W-1:0]  r_peek_ptr;
    logic [CNT_W-1:0]  r_held;
    logic [CNT_W-1:0]  r_peek_rem;

    // Per-transaction working registers.
    logic [1:0]        r_op;
    logic [LEN_W-1:0]  r_len;
    logic [DATA_W-1:0] r_put_bytes;
    logic [LEN_W-1:0]  r_n;
    logic [LEN_W-1:0]  r_cnt;
    logic [PTR_W-1:0]  r_addr;
    logic              r_pend;
    logic [LANE_W-1:0] r_cap_idx;
    logic [DATA_W-1:0] r_acc;
    t_out_item         r_out;

    logic [LEN_W-1:0]  req;
    logic [CNT_W-1:0]  avail;
    logic [LEN_W-1:0]  take;
    logic [PTR_W-1:0]  start;
    logic              issue;
    logic [PTR_W-1:0]  addr_inc;
    logic [BYTE_W-1:0] wdata;
    logic [BYTE_W-1:0] rdata;
    logic [CNT_W-1:0]  n_held;

    always_comb begin
        req = (r_len > LEN_W'(BURST)) ? LEN_W'(BURST) : r_len;
        case (r_op)
            OP_PUT: begin
                avail = CNT_W'(DEPTH) - r_held;
                start = r_wp;
            end
            OP_GET, OP_PEEK: begin
                avail = r_held;
                start = r_rp;
            end
            default: begin
                avail = r_peek_rem;
                start = r_peek_ptr;
            end
        endcase
        // When the available count is below the request it fits the length width.
        take = (CNT_W'(req) < avail) ? req : avail[LEN_W-1:0];

        issue    = (r_cnt != r_n);
        addr_inc = (r_addr == PTR_W'(DEPTH - 1)) ? '0 : r_addr + 1'b1;
        wdata    = r_put_bytes[BYTE_W*r_cnt[LANE_W-1:0] +: BYTE_W];

        case (r_op)
            OP_PUT:  n_held = r_held + CNT_W'(r_n);
            OP_GET:  n_held = r_held - CNT_W'(r_n);
            default: n_held = r_held;
        endcase
    end

    assign o_sts.run_done = !issue && !r_pend;

    brq_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_en   (i_cmd.run && issue),
        .i_we   (r_op == OP_PUT),
        .i_addr (r_addr),
        .i_wdata(wdata),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp       <= '0;
            r_wp       <= '0;
            r_peek_ptr <= '0;
            r_held     <= '0;
            r_peek_rem <= '0;
            r_n        <= '0;
            r_cnt      <= '0;
            r_pend     <= 1'b0;
        end else begin
            if (i_cmd.setup) begin
                r_n    <= take;
                r_cnt  <= '0;
                r_pend <= 1'b0;
            end
            if (i_cmd.run) begin
                if (issue) begin
                    r_cnt <= r_cnt + 1'b1;
                end
                // The store read is registered, so a capture trails each read issue.
                r_pend <= issue && (r_op != OP_PUT);
            end
            if (i_cmd.commit) begin
                r_held <= n_held;
                case (r_op)
                    OP_PUT: r_wp <= r_addr;
                    OP_GET: r_rp <= r_addr;
                    OP_PEEK: begin
                        r_peek_ptr <= r_addr;
                        r_peek_rem <= r_held - CNT_W'(r_n);
                    end
                    default: begin
                        r_peek_ptr <= r_addr;
                        r_peek_rem <= r_peek_rem - CNT_W'(r_n);
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op        <= i_in.operation;
            r_len       <= i_in.length;
            r_put_bytes <= i_in.put_bytes;
        end
        if (i_cmd.setup) begin
            r_addr <= start;
            r_acc  <= '0;
        end
        if (i_cmd.run) begin
            if (issue) begin
                r_addr <= addr_inc;
            end
            r_cap_idx <= r_cnt[LANE_W-1:0];
            if (r_pend) begin
                r_acc[BYTE_W*r_cap_idx +: BYTE_W] <= rdata;
            end
        end
        if (i_cmd.commit) begin
            r_out.read_bytes <= r_acc;
            r_out.moved      <= r_n;
            r_out.fill_level <= n_held;
            r_out.free_space <= CNT_W'(DEPTH) - n_held;
        end
    end

    assign o_out = r_out;

    `BRQ_ASSERT_ALWAYS(a_held_bound, i_clk, i_rst_n, r_held <= CNT_W'(DEPTH), "fill count above depth")
    `BRQ_ASSERT_IMPLY(a_cnt_bound, i_clk, i_rst_n, i_cmd.run, r_cnt <= r_n, "byte counter overran")
    `BRQ_ASSERT_IMPLY(a_no_put_read, i_clk, i_rst_n, r_pend, r_op != OP_PUT, "read capture on put")
    `BRQ_ASSERT_NEXT(a_get_count, i_clk, i_rst_n, i_cmd.commit && (r_op == OP_GET), r_held == $past(r_held) - CNT_W'($past(r_n)), "get did not lower fill count")

endmodule

### design/brq_ctrl.sv
// ----------------------------------------------------------------------------
// brq_ctrl
// Controller: sequences each transaction through setup, the byte loop and
// the hand-off to the output register.
// ----------------------------------------------------------------------------
module brq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output brq_pkg::t_dp_cmd o_cmd,
    input  brq_pkg::t_dp_sts i_sts
);
    import brq_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SETUP = 2'd1;
    localparam logic [1:0] S_RUN   = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       slot_free;
    t_dp_cmd    cmd;

    always_comb begin
        n_state   = r_state;
        cmd       = '0;
        slot_free = !r_out_valid || !i_out_stall;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_SETUP;
                end
            end
            S_SETUP: begin
                cmd.setup = 1'b1;
                n_state   = S_RUN;
            end
            S_RUN: begin
                cmd.run = 1'b1;
                if (i_sts.run_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // A finished result waits here until the output register is free.
                if (slot_free) begin
                    cmd.commit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_out_valid = cmd.commit || (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### design/byte_ring_queue_with_peek_unit.sv
// ----------------------------------------------------------------------------
// byte_ring_queue_with_peek_unit
// Circular byte queue with put, get, peek and peek-next operations of up to
// eight bytes per transaction.
//
//   Channel  Valid        Stall        Payload
//   input    i_in_valid   o_in_stall   i_in  (brq_pkg::t_in_item)
//   output   o_out_valid  i_out_stall  o_out (brq_pkg::t_out_item)
//
// Each transaction runs through setup, the byte loop and the commit before the
// next is accepted; a get or peek that reads bytes also waits for the
// registered store read: the byte store has one port and moves one byte per
// cycle.
// The store needs no clearing after reset; the pointers and counts reset to
// zero.
// A new transaction is accepted while the previous result waits in the
// output register; a stalled output holds the next result in the datapath.
// ----------------------------------------------------------------------------
module byte_ring_queue_with_peek_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  brq_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output brq_pkg::t_out_item o_out
);
    import brq_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    brq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    brq_dp u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd),
        .o_sts  (sts),
        .i_in   (i_in),
        .o_out  (o_out)
    );

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the byte ring queue with peek unit. A short
// directed list is followed by random put, get, peek and peek-next
// transactions in phases that lean toward puts, then gets, then puts again
// and mix the operations. Every result is checked field by field against an
// in-bench model of the ring store, while the sender idles in bursts and the
// receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

    import brq_pkg::*;

    typedef struct {
        t_in_item item;
        bit       settle;
    } t_backlog_entry;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in        = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out;

    // Model of the ring store and its cursors.
    logic [BYTE_W-1:0] ring_mem [DEPTH];
    int ring_rd;
    int ring_wr;
    int ring_held;
    int peek_pos;
    int peek_left;

    t_backlog_entry op_backlog [$];
    t_out_item      expected_replies [$];

    int mismatch_count = 0;
    int burst_left     = 8;
    int gap_left       = 0;
    int stall_mode     = 0;
    int stall_hold     = 0;
    int cycle_no       = 0;
    bit offer;
    bit stall_now;
    t_backlog_entry next_entry;
    t_out_item      want;

    byte_ring_queue_with_peek_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_out_item ring_apply(t_in_item it);
        t_out_item r;
        int        want_n;
        int        n;
        r      = '0;
        n      = 0;
        want_n = (it.length > BURST) ? BURST : int'(it.length);
        case (it.operation)
            OP_PUT: begin
                n = (want_n < DEPTH - ring_held) ? want_n : DEPTH - ring_held;
                for (int i = 0; i < n; i++) begin
                    ring_mem[ring_wr] = it.put_bytes[8*i +: 8];
                    ring_wr = (ring_wr + 1) % DEPTH;
                end
                ring_held += n;
            end
            OP_GET: begin
                n = (want_n < ring_held) ? want_n : ring_held;
                for (int i = 0; i < n; i++)
                    r.read_bytes[8*i +: 8] = ring_mem[(ring_rd + i) % DEPTH];
                ring_rd = (ring_rd + n) % DEPTH;
                ring_held -= n;
            end
            OP_PEEK: begin
                n = (want_n < ring_held) ? want_n : ring_held;
                for (int i = 0; i < n; i++)
                    r.read_bytes[8*i +: 8] = ring_mem[(ring_rd + i) % DEPTH];
                peek_pos  = (ring_rd + n) % DEPTH;
                peek_left = ring_held - n;
            end
            default: begin
                // The cursor may point at bytes already removed or overwritten.
                n = (want_n < peek_left) ? want_n : peek_left;
                for (int i = 0; i < n; i++)
                    r.read_bytes[8*i +: 8] = ring_mem[(peek_pos + i) % DEPTH];
                peek_pos  = (peek_pos + n) % DEPTH;
                peek_left -= n;
            end
        endcase
        r.moved      = LEN_W'(n);
        r.fill_level = CNT_W'(ring_held);
        r.free_space = CNT_W'(DEPTH - ring_held);
        return r;
    endfunction

    task automatic queue_op(logic [1:0] op, int len, logic [DATA_W-1:0] data, bit settle);
        t_backlog_entry e;
        e.item.operation = op;
        e.item.length    = LEN_W'(len);
        e.item.put_bytes = data;
        e.settle         = settle;
        op_backlog.push_back(e);
    endtask

    // Weighted choice of operation; length mostly within a burst, sometimes
    // zero or above the burst size.
    task automatic queue_random_op(int put_w, int get_w, int peek_w, bit settle);
        int                pick;
        int                len;
        logic [1:0]        op;
        logic [DATA_W-1:0] data;
        pick = $urandom_range(0, 99);
        if (pick < put_w)
            op = OP_PUT;
        else if (pick < put_w + get_w)
            op = OP_GET;
        else if (pick < put_w + get_w + peek_w)
            op = OP_PEEK;
        else
            op = OP_PEEK_NEXT;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            len = 0;
        else if (pick < 3)
            len = $urandom_range(9, 15);
        else if (pick < 10)
            len = BURST;
        else
            len = $urandom_range(1, BURST);
        data = {$urandom(), $urandom()};
        pick = $urandom_range(0, 19);
        if (pick == 0)
            data = '1;
        else if (pick == 1)
            data = '0;
        queue_op(op, len, data, settle);
    endtask

    // Sender: bursts of transactions separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in       <= '0;
        end else begin
            offer = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                expected_replies.push_back(ring_apply(i_in));
                offer = 1'b0;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0) begin
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
                    burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 24);
                end
            end
            if (!offer) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (op_backlog.size() > 0 &&
                             (!op_backlog[0].settle || expected_replies.size() == 0)) begin
                    next_entry = op_backlog.pop_front();
                    i_in  <= next_entry.item;
                    offer = 1'b1;
                end
            end
            i_in_valid <= offer;
        end
    end

    // Receiver: checks each result and stalls in changing modes.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_replies.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, o_out);
                    mismatch_count++;
                end else begin
                    want = expected_replies.pop_front();
                    if (o_out.read_bytes !== want.read_bytes) begin
                        $display("%0t: read_bytes expected %h actual %h",
                                 $time, want.read_bytes, o_out.read_bytes);
                        mismatch_count++;
                    end
                    if (o_out.moved !== want.moved) begin
                        $display("%0t: moved expected %0d actual %0d",
                                 $time, want.moved, o_out.moved);
                        mismatch_count++;
                    end
                    if (o_out.fill_level !== want.fill_level) begin
                        $display("%0t: fill_level expected %0d actual %0d",
                                 $time, want.fill_level, o_out.fill_level);
                        mismatch_count++;
                    end
                    if (o_out.free_space !== want.free_space) begin
                        $display("%0t: free_space expected %0d actual %0d",
                                 $time, want.free_space, o_out.free_space);
                        mismatch_count++;
                    end
                end
            end
            cycle_no++;
            if (cycle_no % 300 == 0)
                stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0: stall_now = 1'b0;
                1: stall_now = ($urandom_range(0, 99) < 35);
                default: begin
                    if (stall_hold > 0) begin
                        stall_hold--;
                        stall_now = 1'b1;
                    end else begin
                        stall_now = 1'b0;
                        if ($urandom_range(0, 99) < 15)
                            stall_hold = $urandom_range(1, 30);
                    end
                end
            endcase
            i_out_stall <= stall_now;
        end
    end

    initial begin
        ring_rd   = 0;
        ring_wr   = 0;
        ring_held = 0;
        peek_pos  = 0;
        peek_left = 0;

        // Directed: empty queue, saturated lengths, cursor behavior.
        queue_op(OP_PUT,       0,  64'h1111_2222_3333_4444, 1'b0);
        queue_op(OP_GET,       4,  '0, 1'b0);
        queue_op(OP_PEEK,      8,  '0, 1'b0);
        queue_op(OP_PEEK_NEXT, 8,  '0, 1'b0);
        queue_op(OP_PUT,       15, 64'h0123_4567_89AB_CDEF, 1'b0);
        queue_op(OP_PUT,       3,  '1, 1'b0);
        queue_op(OP_PEEK,      4,  '0, 1'b0);
        queue_op(OP_PEEK_NEXT, 4,  '0, 1'b0);
        queue_op(OP_PEEK_NEXT, 8,  '0, 1'b0);
        queue_op(OP_PEEK,      2,  '0, 1'b0);
        queue_op(OP_GET,       15, '0, 1'b0);
        // Reads bytes that the get above has already removed.
        queue_op(OP_PEEK_NEXT, 8,  '0, 1'b0);
        queue_op(OP_PUT,       8,  '0, 1'b0);
        queue_op(OP_PEEK_NEXT, 9,  '0, 1'b0);
        queue_op(OP_GET,       0,  '0, 1'b0);
        queue_op(OP_PEEK,      0,  '0, 1'b0);
        queue_op(OP_PUT,       8,  {$urandom(), $urandom()}, 1'b0);
        queue_op(OP_PEEK_NEXT, 12, '0, 1'b0);
        queue_op(OP_GET,       8,  '0, 1'b0);
        queue_op(OP_GET,       8,  '0, 1'b0);
        queue_op(OP_GET,       8,  '0, 1'b0);

        // Random phases: mostly puts, mostly gets, mostly puts again, then mixed.
        for (int i = 0; i < 200; i++)
            queue_random_op(80, 10, 5, i == 0);
        for (int i = 0; i < 200; i++)
            queue_random_op(15, 65, 10, i == 0);
        for (int i = 0; i < 170; i++)
            queue_random_op(70, 15, 8, i == 0);
        for (int i = 0; i < 180; i++)
            queue_random_op(25, 25, 25, i == 0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (op_backlog.size() > 0 || i_in_valid || expected_replies.size() > 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #6_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, expected_replies.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
